FILE: sv/mwc_pkg.sv
package mwc_pkg;

  localparam int WINDOW_SIDE = 6;
  localparam int PIXEL_BITS  = 16;
  localparam int FRAC_BITS   = 8;

  localparam int PIX_IN_W = 16;
  localparam int MASK_W   = 16;
  localparam int CENT_W   = 11;
  localparam int TFLUX_W  = 22;

  localparam int IDX_W   = $clog2(WINDOW_SIDE);
  localparam int WT_W    = $clog2(WINDOW_SIDE + 1);
  localparam int FLUX_W  = PIXEL_BITS + $clog2(WINDOW_SIDE * WINDOW_SIDE);
  localparam int WSUM_W  = FLUX_W + WT_W;
  localparam int PROD_W  = PIXEL_BITS + WT_W;
  localparam int Q_W     = FRAC_BITS + WT_W;
  localparam int DIVD_W  = WSUM_W + FRAC_BITS;
  localparam int STEP_W  = $clog2(Q_W);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CENT_MAX = (WINDOW_SIDE - 1) * (2 ** FRAC_BITS);

  typedef struct packed {
    logic [FLUX_W-1:0] flux;
    logic [WSUM_W-1:0] row_sum;
    logic [WSUM_W-1:0] col_sum;
  } win_sums_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } back_state_t;

endpackage

FILE: sv/mwc_front.sv
module mwc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [mwc_pkg::PIX_IN_W-1:0]   pixel_value,
  input  logic signed [mwc_pkg::MASK_W-1:0] mask_value,
  output logic                           q_push,
  output mwc_pkg::win_sums_t             q_data,
  input  logic                           q_full
);
  import mwc_pkg::*;

  logic [IDX_W-1:0]      row_index;
  logic [IDX_W-1:0]      col_index;
  logic [FLUX_W-1:0]     flux_sum;
  logic [WSUM_W-1:0]     row_weighted_sum;
  logic [WSUM_W-1:0]     col_weighted_sum;

  logic                  counted;
  logic                  at_last;
  logic                  accept;
  logic [PIXEL_BITS-1:0] pix;
  logic [WT_W-1:0]       row_wt;
  logic [WT_W-1:0]       col_wt;
  logic [PROD_W-1:0]     row_prod;
  logic [PROD_W-1:0]     col_prod;
  win_sums_t             sums_next;

  assign counted = !mask_value[MASK_W-1] && (mask_value != '0);
  assign pix     = counted ? pixel_value[PIXEL_BITS-1:0] : '0;
  assign row_wt  = WT_W'(row_index) + WT_W'(1);
  assign col_wt  = WT_W'(col_index) + WT_W'(1);

  assign row_prod = PROD_W'(pix) * PROD_W'(row_wt);
  assign col_prod = PROD_W'(pix) * PROD_W'(col_wt);

  assign sums_next.flux    = flux_sum + FLUX_W'(pix);
  assign sums_next.row_sum = row_weighted_sum + WSUM_W'(row_prod);
  assign sums_next.col_sum = col_weighted_sum + WSUM_W'(col_prod);

  assign at_last = (row_index == IDX_W'(WINDOW_SIDE - 1)) &&
                   (col_index == IDX_W'(WINDOW_SIDE - 1));
  assign full    = q_full && at_last;
  assign accept  = push && !full;
  assign q_push  = accept && at_last;
  assign q_data  = sums_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index        <= '0;
      col_index        <= '0;
      flux_sum         <= '0;
      row_weighted_sum <= '0;
      col_weighted_sum <= '0;
    end else if (accept) begin
      if (col_index == IDX_W'(WINDOW_SIDE - 1)) begin
        col_index <= '0;
        row_index <= (row_index == IDX_W'(WINDOW_SIDE - 1)) ? '0 : row_index + IDX_W'(1);
      end else begin
        col_index <= col_index + IDX_W'(1);
      end
      if (at_last) begin
        flux_sum         <= '0;
        row_weighted_sum <= '0;
        col_weighted_sum <= '0;
      end else begin
        flux_sum         <= sums_next.flux;
        row_weighted_sum <= sums_next.row_sum;
        col_weighted_sum <= sums_next.col_sum;
      end
    end
  end

endmodule

FILE: sv/mwc_queue.sv
module mwc_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  mwc_pkg::win_sums_t wr_data,
  output logic               q_full,
  input  logic               rd_en,
  output mwc_pkg::win_sums_t rd_data,
  output logic               q_empty
);
  import mwc_pkg::*;

  win_sums_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: sv/mwc_back.sv
module mwc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  mwc_pkg::win_sums_t           q_data,
  output logic                         q_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic [mwc_pkg::CENT_W-1:0]   centroid_row,
  output logic [mwc_pkg::CENT_W-1:0]   centroid_col,
  output logic [mwc_pkg::TFLUX_W-1:0]  total_flux,
  output logic                         empty_flag
);
  import mwc_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic [FLUX_W-1:0] divisor;
  logic [FLUX_W-1:0] rem_row;
  logic [FLUX_W-1:0] rem_col;
  logic [Q_W-1:0]    quo_row;
  logic [Q_W-1:0]    quo_col;
  logic [STEP_W-1:0] step;
  logic              is_empty;

  logic [DIVD_W-1:0] dvd_row;
  logic [DIVD_W-1:0] dvd_col;
  logic [FLUX_W:0]   trial_row;
  logic [FLUX_W:0]   trial_col;
  logic              ge_row;
  logic              ge_col;
  logic [FLUX_W-1:0] rem_row_next;
  logic [FLUX_W-1:0] rem_col_next;
  logic [Q_W-1:0]    cent_row_q;
  logic [Q_W-1:0]    cent_col_q;
  logic              load;
  logic              last_step;

  assign dvd_row = {q_data.row_sum, {FRAC_BITS{1'b0}}};
  assign dvd_col = {q_data.col_sum, {FRAC_BITS{1'b0}}};

  assign trial_row = {rem_row, quo_row[Q_W-1]};
  assign trial_col = {rem_col, quo_col[Q_W-1]};
  assign ge_row    = trial_row >= {1'b0, divisor};
  assign ge_col    = trial_col >= {1'b0, divisor};
  assign rem_row_next = ge_row ? FLUX_W'(trial_row - {1'b0, divisor}) : trial_row[FLUX_W-1:0];
  assign rem_col_next = ge_col ? FLUX_W'(trial_col - {1'b0, divisor}) : trial_col[FLUX_W-1:0];

  assign last_step = (step == STEP_W'(Q_W - 1));

  always_comb begin
    state_next = state;
    load       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          load       = 1'b1;
          state_next = (q_data.flux == '0) ? ST_HOLD : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_step) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (pop) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign q_pop = load;
  assign empty = (state != ST_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      divisor  <= q_data.flux;
      is_empty <= (q_data.flux == '0);
      rem_row  <= dvd_row[DIVD_W-1:Q_W];
      rem_col  <= dvd_col[DIVD_W-1:Q_W];
      quo_row  <= dvd_row[Q_W-1:0];
      quo_col  <= dvd_col[Q_W-1:0];
      step     <= '0;
    end else if (state == ST_RUN) begin
      rem_row <= rem_row_next;
      rem_col <= rem_col_next;
      quo_row <= {quo_row[Q_W-2:0], ge_row};
      quo_col <= {quo_col[Q_W-2:0], ge_col};
      step    <= step + STEP_W'(1);
    end
  end

  assign cent_row_q = (quo_row >= Q_W'(2 ** FRAC_BITS)) ? quo_row - Q_W'(2 ** FRAC_BITS) : '0;
  assign cent_col_q = (quo_col >= Q_W'(2 ** FRAC_BITS)) ? quo_col - Q_W'(2 ** FRAC_BITS) : '0;

  assign centroid_row = is_empty ? '0 : CENT_W'(cent_row_q);
  assign centroid_col = is_empty ? '0 : CENT_W'(cent_col_q);
  assign total_flux   = is_empty ? '0 : TFLUX_W'(divisor);
  assign empty_flag   = is_empty;

endmodule

FILE: sv/masked_window_centroid_core.sv
// Pixels are taken one per cycle while full is low; a 6x6 window is one transaction per
// pixel. A window's sums pass through the two-entry sums queue to a restoring divider that
// retires one quotient bit per cycle for both centroids together; the result is shown as
// the last bit retires. A window whose total is zero skips the divider.
// Synchronous reset clears the window position, running sums, queue and back-end state.
module masked_window_centroid_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [mwc_pkg::PIX_IN_W-1:0]     pixel_value,
  input  logic signed [mwc_pkg::MASK_W-1:0] mask_value,
  output logic                             empty,
  input  logic                             pop,
  output logic [mwc_pkg::CENT_W-1:0]       centroid_row,
  output logic [mwc_pkg::CENT_W-1:0]       centroid_col,
  output logic [mwc_pkg::TFLUX_W-1:0]      total_flux,
  output logic                             empty_flag
);
  import mwc_pkg::*;

  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  win_sums_t q_wr_data;
  win_sums_t q_rd_data;

  mwc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .pixel_value (pixel_value),
    .mask_value  (mask_value),
    .q_push      (q_push),
    .q_data      (q_wr_data),
    .q_full      (q_full)
  );

  mwc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .q_empty (q_empty)
  );

  mwc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (q_rd_data),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .centroid_row (centroid_row),
    .centroid_col (centroid_col),
    .total_flux   (total_flux),
    .empty_flag   (empty_flag)
  );

  a_no_push_when_full : assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("window sums pushed into a full queue");

  a_pop_clears_result : assert property (@(posedge clk) disable iff (rst)
    (pop && !empty) |=> empty)
    else $error("result still shown after its transaction");

  a_empty_window_zero : assert property (@(posedge clk) disable iff (rst)
    (!empty && empty_flag) |->
      (centroid_row == '0 && centroid_col == '0 && total_flux == '0))
    else $error("empty window with nonzero result fields");

  a_centroid_range : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (centroid_row <= CENT_W'(CENT_MAX) && centroid_col <= CENT_W'(CENT_MAX)))
    else $error("centroid outside the window");

endmodule
